### rtl/u8af_pkg.sv
// ----------------------------------------------------------------------------
// u8af_pkg
// Shared types and helpers for the UTF-8 accent folding unit: the command
// that passes from the decoder to the encoder, the fold table and the
// UTF-8 re-encoding helpers.
// ----------------------------------------------------------------------------
package u8af_pkg;

    localparam int CP_W          = 21;
    localparam int LEN_W         = 3;
    localparam int QUEUE_DEPTH_D = 4;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    // One decoded, folded code point (or a pure end marker when len is 0)
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic             last;
        logic             bad;
    } t_cmd;

    // Latin accent table: fold accented letters to plain lower case
    function automatic logic [CP_W-1:0] fold_cp(input logic [CP_W-1:0] c);
        logic [CP_W-1:0] r;
        r = c;
        if ((c >= 21'hC0 && c <= 21'hC5) || (c >= 21'hE0 && c <= 21'hE5)) begin
            r = 21'h61;
        end else if ((c >= 21'hC8 && c <= 21'hCB) || (c >= 21'hE8 && c <= 21'hEB)) begin
            r = 21'h65;
        end else if ((c >= 21'hCC && c <= 21'hCF) || (c >= 21'hEC && c <= 21'hEF)) begin
            r = 21'h69;
        end else if ((c >= 21'hD2 && c <= 21'hD6) || (c >= 21'hF2 && c <= 21'hF6)) begin
            r = 21'h6F;
        end else if ((c >= 21'hD9 && c <= 21'hDC) || (c >= 21'hF9 && c <= 21'hFC)) begin
            r = 21'h75;
        end else if (c == 21'hDD || c == 21'hFD || c == 21'hFF || c == 21'h178) begin
            r = 21'h79;
        end else if (c == 21'hC7 || c == 21'hE7) begin
            r = 21'h63;
        end else if (c == 21'hD1 || c == 21'hF1) begin
            r = 21'h6E;
        end else if (c == 21'hDF) begin
            r = 21'h73;
        end
        return r;
    endfunction

    // Number of output bytes for a folded code point; 0 means dropped
    function automatic logic [LEN_W-1:0] enc_len(input logic [CP_W-1:0] c,
                                                 input logic keep);
        logic [LEN_W-1:0] r;
        if (c < CP_W'(ASCII_LIMIT)) begin
            r = 3'd1;
        end else if (!keep) begin
            r = 3'd0;
        end else if (c < 21'h800) begin
            r = 3'd2;
        end else if (c < 21'h10000) begin
            r = 3'd3;
        end else begin
            r = 3'd4;
        end
        return r;
    endfunction

    // Byte k of the UTF-8 form of c, which is len bytes long
    function automatic logic [7:0] enc_byte(input logic [CP_W-1:0] c,
                                            input logic [LEN_W-1:0] len,
                                            input logic [1:0] k);
        logic [7:0] r;
        unique case (len)
            3'd2: r = (k == 2'd0) ? {3'b110, c[10:6]} : {2'b10, c[5:0]};
            3'd3: begin
                unique case (k)
                    2'd0:    r = {4'b1110, c[15:12]};
                    2'd1:    r = {2'b10, c[11:6]};
                    default: r = {2'b10, c[5:0]};
                endcase
            end
            3'd4: begin
                unique case (k)
                    2'd0:    r = {5'b11110, c[20:18]};
                    2'd1:    r = {2'b10, c[17:12]};
                    2'd2:    r = {2'b10, c[11:6]};
                    default: r = {2'b10, c[5:0]};
                endcase
            end
            default: r = c[7:0];
        endcase
        return r;
    endfunction

endpackage

### rtl/utf8_accent_fold_to_ascii_unit.sv
// ----------------------------------------------------------------------------
// utf8_accent_fold_to_ascii_unit
// UTF-8 decoder with Latin accent folding and optional UTF-8 re-encoding.
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------
//   input     push / full          i_in_byte, i_end_of_input
//   result    pop / empty          o_out_byte, o_byte_present,
//                                  o_end_of_output, o_bad_sequence
//   config    i_cfg_wr_en          i_cfg_wr_data (keep_non_ascii)
//
// One input byte is taken per cycle while the command queue has room.
// Results leave at one byte per cycle while popped; a code point of n bytes
// holds the encoder until its last byte is loaded. An accepted command goes
// to the queue, then to the result register, which drives empty low. Reset
// empties the queue and result register and returns the unit to mode 0.
// ----------------------------------------------------------------------------
module utf8_accent_fold_to_ascii_unit
    import u8af_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_present,
    output logic       o_end_of_output,
    output logic       o_bad_sequence
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic queue_empty;
    logic queue_full;
    logic back_pop;
    logic accept;

    assign accept = push && !queue_full;
    assign full   = queue_full;

    u8af_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_accept       (accept),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_cmd_push     (front_push),
        .o_cmd          (front_cmd)
    );

    u8af_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_cmd   (queue_cmd),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    u8af_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (queue_cmd),
        .i_cmd_empty     (queue_empty),
        .o_cmd_pop       (back_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_byte      (o_out_byte),
        .o_byte_present  (o_byte_present),
        .o_end_of_output (o_end_of_output),
        .o_bad_sequence  (o_bad_sequence)
    );

endmodule

### rtl/u8af_front.sv
// ----------------------------------------------------------------------------
// u8af_front
// UTF-8 decoder: validates the byte stream, gathers code points, folds them
// and issues one command per kept character or end marker.
// ----------------------------------------------------------------------------
module u8af_front
    import u8af_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    // Allowed range of the next continuation byte
    typedef enum logic [2:0] {
        CLS_NONE = 3'd0,
        CLS_E0   = 3'd1,
        CLS_ED   = 3'd2,
        CLS_F0   = 3'd3,
        CLS_F4   = 3'd4,
        CLS_ANY  = 3'd5
    } t_cls;

    logic [CP_W-1:0] r_cp,   n_cp;
    logic [1:0]      r_need, n_need;
    t_cls            r_cls,  n_cls;
    logic            r_err,  n_err;
    logic            r_keep;

    logic            emit;
    logic [CP_W-1:0] emit_cp;
    logic            consumed;
    logic            cont_ok;
    logic [CP_W-1:0] folded;
    logic [LEN_W-1:0] len;

    always_comb begin
        unique case (r_cls)
            CLS_E0:  cont_ok = i_in_byte >= 8'hA0 && i_in_byte <= 8'hBF;
            CLS_ED:  cont_ok = i_in_byte >= 8'h80 && i_in_byte <= 8'h9F;
            CLS_F0:  cont_ok = i_in_byte >= 8'h90 && i_in_byte <= 8'hBF;
            CLS_F4:  cont_ok = i_in_byte >= 8'h80 && i_in_byte <= 8'h8F;
            default: cont_ok = i_in_byte >= 8'h80 && i_in_byte <= 8'hBF;
        endcase
    end

    always_comb begin
        n_cp     = r_cp;
        n_need   = r_need;
        n_cls    = r_cls;
        n_err    = r_err;
        emit     = 1'b0;
        emit_cp  = '0;
        consumed = 1'b0;

        if (r_need != 2'd0) begin
            if (i_in_byte[7:6] == 2'b10) begin
                consumed = 1'b1;
                if (!cont_ok) begin
                    n_err  = 1'b1;
                    n_cp   = '0;
                    n_need = 2'd0;
                    n_cls  = CLS_NONE;
                end else begin
                    n_cp   = {r_cp[CP_W-7:0], i_in_byte[5:0]};
                    n_cls  = CLS_NONE;
                    n_need = r_need - 2'd1;
                    if (n_need == 2'd0) begin
                        emit    = 1'b1;
                        emit_cp = n_cp;
                        n_cp    = '0;
                    end
                end
            end else begin
                // abandon the open sequence, treat the byte as a new lead
                n_err  = 1'b1;
                n_cp   = '0;
                n_need = 2'd0;
                n_cls  = CLS_NONE;
            end
        end

        if (!consumed) begin
            if (i_in_byte < ASCII_LIMIT) begin
                emit    = 1'b1;
                emit_cp = CP_W'(i_in_byte);
            end else if (i_in_byte >= 8'hC2 && i_in_byte <= 8'hDF) begin
                n_cp   = CP_W'(i_in_byte[4:0]);
                n_need = 2'd1;
                n_cls  = CLS_ANY;
            end else if (i_in_byte >= 8'hE0 && i_in_byte <= 8'hEF) begin
                n_cp   = CP_W'(i_in_byte[3:0]);
                n_need = 2'd2;
                n_cls  = (i_in_byte == 8'hE0) ? CLS_E0 :
                         (i_in_byte == 8'hED) ? CLS_ED : CLS_ANY;
            end else if (i_in_byte >= 8'hF0 && i_in_byte <= 8'hF4) begin
                n_cp   = CP_W'(i_in_byte[2:0]);
                n_need = 2'd3;
                n_cls  = (i_in_byte == 8'hF0) ? CLS_F0 :
                         (i_in_byte == 8'hF4) ? CLS_F4 : CLS_ANY;
            end else begin
                n_err  = 1'b1;
                n_cp   = '0;
                n_need = 2'd0;
                n_cls  = CLS_NONE;
            end
        end

        // truncated sequence at end of string
        if (i_end_of_input && n_need != 2'd0) begin
            n_err = 1'b1;
        end
    end

    assign folded = fold_cp(emit_cp);
    assign len    = emit ? enc_len(folded, r_keep) : 3'd0;

    always_comb begin
        o_cmd.cp   = folded;
        o_cmd.len  = len;
        o_cmd.last = i_end_of_input;
        o_cmd.bad  = i_end_of_input & n_err;
        o_cmd_push = i_accept && (len != 3'd0 || i_end_of_input);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp   <= '0;
            r_need <= 2'd0;
            r_cls  <= CLS_NONE;
            r_err  <= 1'b0;
            r_keep <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_keep <= i_cfg_wr_data;
            end
            if (i_accept) begin
                if (i_end_of_input) begin
                    // clear the decoder state once the string is done
                    r_cp   <= '0;
                    r_need <= 2'd0;
                    r_cls  <= CLS_NONE;
                    r_err  <= 1'b0;
                end else begin
                    r_cp   <= n_cp;
                    r_need <= n_need;
                    r_cls  <= n_cls;
                    r_err  <= n_err;
                end
            end
        end
    end

endmodule

### rtl/u8af_queue.sv
// ----------------------------------------------------------------------------
// u8af_queue
// Small command queue between decoder and encoder.
// ----------------------------------------------------------------------------
module u8af_queue
    import u8af_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_D
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/u8af_back.sv
// ----------------------------------------------------------------------------
// u8af_back
// Encoder: expands each command into its UTF-8 bytes in the result
// register, one per cycle while that register is free or being popped.
// ----------------------------------------------------------------------------
module u8af_back
    import u8af_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_empty,
    output logic       o_cmd_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_byte_present,
    output logic       o_end_of_output,
    output logic       o_bad_sequence
);

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic       r_present;
    logic       r_end;
    logic       r_bad;

    logic       load;
    logic [1:0] last_idx;
    logic       at_last;

    assign load      = !r_valid || i_pop;
    assign last_idx  = (i_cmd.len == 3'd0) ? 2'd0 : 2'(i_cmd.len - 3'd1);
    assign at_last   = (r_idx == last_idx);
    assign o_cmd_pop = load && !i_cmd_empty && at_last;

    assign o_empty         = !r_valid;
    assign o_out_byte      = r_byte;
    assign o_byte_present  = r_present;
    assign o_end_of_output = r_end;
    assign o_bad_sequence  = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_idx     <= 2'd0;
            r_byte    <= '0;
            r_present <= 1'b0;
            r_end     <= 1'b0;
            r_bad     <= 1'b0;
        end else if (load) begin
            if (!i_cmd_empty) begin
                r_valid   <= 1'b1;
                r_present <= (i_cmd.len != 3'd0);
                r_byte    <= (i_cmd.len == 3'd0) ? 8'h00 : enc_byte(i_cmd.cp, i_cmd.len, r_idx);
                r_end     <= at_last && i_cmd.last;
                r_bad     <= at_last && i_cmd.last && i_cmd.bad;
                // advance through the bytes, pop on the final one
                r_idx     <= at_last ? 2'd0 : r_idx + 2'd1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/u8af_checker.sv
// ----------------------------------------------------------------------------
// u8af_checker
// Port-level checks on the result channel of the accent folding unit.
// ----------------------------------------------------------------------------
module u8af_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_byte_present,
    input logic       o_end_of_output,
    input logic       o_bad_sequence
);

    // a waiting transaction stays until taken
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("result withdrawn before pop");

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_out_byte) && $stable(o_end_of_output))
        else $error("stalled result changed");

    // a result with no character is only ever an end marker, and carries zero
    a_marker_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_byte_present |-> o_end_of_output && o_out_byte == 8'h00)
        else $error("empty result without end marker");

    a_bad_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_bad_sequence |-> o_end_of_output)
        else $error("error flag away from end of string");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty)
        else $error("result shown straight after reset");

endmodule

bind utf8_accent_fold_to_ascii_unit u8af_checker u_u8af_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_out_byte      (o_out_byte),
    .o_byte_present  (o_byte_present),
    .o_end_of_output (o_end_of_output),
    .o_bad_sequence  (o_bad_sequence)
);
